/* sv/linear_fade_dimmer_unit_assert.svh */
// assertion macros for the linear fade dimmer
// expects clk and arst_n in the scope of use; no other dependencies
`ifndef LINEAR_FADE_DIMMER_UNIT_ASSERT_SVH
`define LINEAR_FADE_DIMMER_UNIT_ASSERT_SVH

// implication in the same cycle
`define LFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication in the next cycle
`define LFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/lfd_pkg.sv */
// shared types and constants of the linear fade dimmer
// no dependencies
`default_nettype none

package lfd_pkg;

	localparam int MAX_LEVEL  = 99;
	localparam int TIME_BITS  = 32;
	localparam int LEVEL_W    = 7;
	localparam int VALUE_W    = 8;
	localparam int OP_W       = 3;
	localparam int STEP_W     = 10;
	localparam int PROD_W     = TIME_BITS + LEVEL_W;
	localparam int CNT_W      = $clog2(PROD_W + 1);

	localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(10);
	localparam logic [LEVEL_W-1:0] LEVEL_MAX  = LEVEL_W'(MAX_LEVEL);

	// operation codes
	localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
	localparam logic [OP_W-1:0] OP_FADE_TO    = 3'd1;
	localparam logic [OP_W-1:0] OP_SET_NOW    = 3'd2;
	localparam logic [OP_W-1:0] OP_SET_BRIGHT = 3'd3;
	localparam logic [OP_W-1:0] OP_SWITCH_ON  = 3'd4;
	localparam logic [OP_W-1:0] OP_SWITCH_OFF = 3'd5;

	// divider request and response
	typedef struct packed {
		logic                 start;
		logic [PROD_W-1:0]    dividend;
		logic [TIME_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [LEVEL_W-1:0] quotient;
	} div_rsp_t;

	// saturate an input value to the top level
	function automatic logic [LEVEL_W-1:0] sat_level(input logic [VALUE_W-1:0] v);
		logic [LEVEL_W-1:0] r;
		if (v > VALUE_W'(MAX_LEVEL)) begin
			r = LEVEL_MAX;
		end else begin
			r = v[LEVEL_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/lfd_if.sv */
// channel interfaces of the linear fade dimmer: command, result, step time
// depends on lfd_pkg for field widths
`default_nettype none

interface lfd_in_if;
	logic                             valid;
	logic                             ready;
	logic [lfd_pkg::OP_W-1:0]         operation;
	logic [lfd_pkg::VALUE_W-1:0]      value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface

interface lfd_out_if;
	logic                             valid;
	logic                             ready;
	logic [lfd_pkg::LEVEL_W-1:0]      level;
	logic                             fading;

	modport source (output valid, output level, output fading, input ready);
	modport sink (input valid, input level, input fading, output ready);
endinterface

interface lfd_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [lfd_pkg::STEP_W-1:0]       data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/lfd_div.sv */
// serial restoring divider, one quotient bit per cycle
// depends on lfd_pkg for widths and the request/response structs
`default_nettype none

module lfd_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lfd_pkg::div_req_t req,
	output lfd_pkg::div_rsp_t      rsp
);

	logic [lfd_pkg::CNT_W-1:0]     cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [lfd_pkg::TIME_BITS-1:0] rem_q;
	logic [lfd_pkg::PROD_W-1:0]    quo_q;
	logic [lfd_pkg::TIME_BITS-1:0] den_q;

	logic [lfd_pkg::TIME_BITS:0]   trial;
	logic                          fits;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[lfd_pkg::PROD_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= lfd_pkg::CNT_W'(lfd_pkg::PROD_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - lfd_pkg::CNT_W'(1);
				if (cnt_q == lfd_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= lfd_pkg::TIME_BITS'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[lfd_pkg::TIME_BITS-1:0];
			end
			quo_q <= {quo_q[lfd_pkg::PROD_W-2:0], fits};
		end
	end

	// quotient never exceeds the level span
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q[lfd_pkg::LEVEL_W-1:0];

endmodule

`default_nettype wire

/* sv/linear_fade_dimmer_unit.sv */
// linear fade dimmer top level: command decode, ramp state and step sequencer
// depends on lfd_pkg, lfd_if, lfd_div and linear_fade_dimmer_unit_assert.svh
//
//   channel   dir   beat contents
//   cmd       in    operation, value
//   res       out   level, fading
//   cfg       in    data (step time in ms)
//
// a command passes through exec and out from accept to the next accept, a tick
// also through step; a tick on an interpolated ramp step adds mul, div and fin
// one item at a time: cmd.ready is high only while the sequencer is idle
// a result waits in the output register; the next command is taken meanwhile
// and holds in its last state until that register frees
// reset is immediate: no clearing pass; cfg.ready is always high
`default_nettype none

module linear_fade_dimmer_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lfd_in_if.sink     cmd,
	lfd_out_if.source  res,
	lfd_cfg_if.sink    cfg
);

	`include "linear_fade_dimmer_unit_assert.svh"

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_EXEC = 7'b0000010,
		S_STEP = 7'b0000100,
		S_MUL  = 7'b0001000,
		S_DIV  = 7'b0010000,
		S_FIN  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	localparam int TB = lfd_pkg::TIME_BITS;
	localparam int LW = lfd_pkg::LEVEL_W;

	state_t                       state_q;
	logic [lfd_pkg::OP_W-1:0]     op_q;
	logic [LW-1:0]                val_q;
	logic [lfd_pkg::STEP_W-1:0]   step_q;
	logic [TB-1:0]                now_q;
	logic [LW-1:0]                cur_q;
	logic [LW-1:0]                start_q;
	logic [LW-1:0]                tgt_q;
	logic [LW-1:0]                rem_q;
	logic [TB-1:0]                rstart_q;
	logic [TB-1:0]                rend_q;
	logic [TB-1:0]                next_q;
	logic [TB-1:0]                num_q;
	logic [TB-1:0]                den_q;
	logic                         res_valid_q;
	logic [LW-1:0]                res_level_q;
	logic                         res_fading_q;

	lfd_pkg::div_req_t            div_req;
	lfd_pkg::div_rsp_t            div_rsp;

	logic                         fade_en;
	logic [LW-1:0]                fade_lvl;
	logic [LW-1:0]                fade_diff;
	logic [LW+lfd_pkg::STEP_W-1:0] fade_prod;
	logic [TB-1:0]                now_plus_step;
	logic [TB-1:0]                elapsed;
	logic [TB-1:0]                ramp_len;
	logic                         rising;
	logic [LW-1:0]                span;
	logic [LW-1:0]                interp;

	assign cmd.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// fade request decode for the command in flight
	always_comb begin
		fade_en  = 1'b0;
		fade_lvl = val_q;
		unique case (op_q)
			lfd_pkg::OP_FADE_TO: begin
				fade_en = 1'b1;
			end
			lfd_pkg::OP_SET_BRIGHT: begin
				fade_en = (cur_q != '0);
			end
			lfd_pkg::OP_SWITCH_ON: begin
				fade_en  = (rend_q == '0);
				fade_lvl = rem_q;
			end
			lfd_pkg::OP_SWITCH_OFF: begin
				fade_en  = 1'b1;
				fade_lvl = '0;
			end
			default: begin
				fade_en = 1'b0;
			end
		endcase
	end

	// ramp length and step timing
	assign fade_diff     = (cur_q > fade_lvl) ? cur_q - fade_lvl : fade_lvl - cur_q;
	assign fade_prod     = (LW+lfd_pkg::STEP_W)'(fade_diff) * (LW+lfd_pkg::STEP_W)'(step_q);
	assign now_plus_step = now_q + TB'(step_q);
	assign elapsed       = now_q - rstart_q;
	assign ramp_len      = rend_q - rstart_q;

	// interpolation between start and target
	assign rising = (tgt_q >= start_q);
	assign span   = rising ? tgt_q - start_q : start_q - tgt_q;
	assign interp = rising ? start_q + div_rsp.quotient : start_q - div_rsp.quotient;

	assign div_req.start    = (state_q == S_MUL);
	assign div_req.dividend = lfd_pkg::PROD_W'(num_q) * lfd_pkg::PROD_W'(span);
	assign div_req.divisor  = den_q;

	lfd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// step time register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= lfd_pkg::STEP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			step_q <= cfg.data;
		end
	end

	// command register
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_q  <= cmd.operation;
			val_q <= lfd_pkg::sat_level(cmd.value);
		end
	end

	// sequencer and ramp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			now_q        <= '0;
			cur_q        <= '0;
			start_q      <= '0;
			tgt_q        <= '0;
			rem_q        <= lfd_pkg::LEVEL_MAX;
			rstart_q     <= '0;
			rend_q       <= '0;
			next_q       <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!res_valid_q || res.ready)) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= (op_q == lfd_pkg::OP_TICK) ? S_STEP : S_OUT;
					if (op_q == lfd_pkg::OP_TICK) begin
						now_q <= now_q + TB'(1);
					end else if (op_q == lfd_pkg::OP_SET_NOW) begin
						tgt_q  <= val_q;
						cur_q  <= val_q;
						rend_q <= '0;
						next_q <= now_plus_step;
					end else begin
						if (op_q == lfd_pkg::OP_SET_BRIGHT && cur_q == '0) begin
							rem_q <= val_q;
						end
						if (op_q == lfd_pkg::OP_SWITCH_OFF && tgt_q != '0) begin
							rem_q <= tgt_q;
						end
						if (fade_en) begin
							start_q  <= cur_q;
							tgt_q    <= fade_lvl;
							rstart_q <= now_q;
							rend_q   <= now_q + TB'(fade_prod);
							next_q   <= now_plus_step;
						end
					end
				end
				S_STEP: begin
					if (rend_q != '0 && now_q >= next_q) begin
						next_q <= now_plus_step;
						if (now_plus_step > rend_q) begin
							cur_q   <= tgt_q;
							rend_q  <= '0;
							state_q <= S_OUT;
						end else if (ramp_len == '0) begin
							cur_q   <= tgt_q;
							state_q <= S_OUT;
						end else begin
							num_q   <= (elapsed > ramp_len) ? ramp_len : elapsed;
							den_q   <= ramp_len;
							state_q <= S_MUL;
						end
					end else begin
						state_q <= S_OUT;
					end
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					cur_q   <= (interp > lfd_pkg::LEVEL_MAX) ? lfd_pkg::LEVEL_MAX : interp;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!res_valid_q || res.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!res_valid_q || res.ready)) begin
			res_level_q  <= cur_q;
			res_fading_q <= (rend_q != '0);
		end
	end

	assign res.valid  = res_valid_q;
	assign res.level  = res_level_q;
	assign res.fading = res_fading_q;

	// checks
	`LFD_ASSERT_NOW(a_level_range, res.valid, res.level <= lfd_pkg::LEVEL_MAX, "level above maximum")
	`LFD_ASSERT_NEXT(a_accept_exec, cmd.valid && cmd.ready, state_q == S_EXEC, "accept did not start")
	`LFD_ASSERT_NOW(a_quot_span, state_q == S_DIV && div_rsp.done, div_rsp.quotient <= span, "quotient beyond span")

endmodule

`default_nettype wire
